// File: rtl/json_string_field_extractor_unit_assert.svh
// Assertion macros for the JSON string field extractor.
// Needs clk and rst_n in the scope of the module that includes it.
`ifndef JSON_STRING_FIELD_EXTRACTOR_UNIT_ASSERT_SVH
`define JSON_STRING_FIELD_EXTRACTOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define JSFX_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsfx same-cycle check failed");

// Next-cycle implication.
`define JSFX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsfx next-cycle check failed");

`endif

// File: rtl/jsfx_pkg.sv
// Package for the JSON string field extractor: character codes,
// register indexes and small helpers. No dependencies.
`default_nettype none

package jsfx_pkg;

    localparam int MAX_KEY_CHARS = 16;
    localparam int HEX_DIGITS    = 4;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    typedef enum logic [1:0] {
        REG_KEY_LOW  = 2'd0,
        REG_KEY_HIGH = 2'd1,
        REG_KEY_LEN  = 2'd2,
        REG_MAX_LEN  = 2'd3
    } cfg_index_t;

    localparam logic [63:0] KEY_LOW_RESET  = 64'd1684632435;
    localparam logic [63:0] KEY_HIGH_RESET = 64'd0;
    localparam logic [4:0]  KEY_LEN_RESET  = 5'd4;
    localparam logic [7:0]  MAX_LEN_RESET  = 8'd63;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

endpackage

`default_nettype wire

// File: rtl/json_string_field_extractor_unit.sv
// JSON string field extractor: scans text words for a quoted key and
// returns the unescaped string value, then one status word.
// Depends on jsfx_pkg and json_string_field_extractor_unit_assert.svh.
// Each text word is held in the input register, then its result in the result register.
// Throughput: one text word per cycle unless out_ready stalls the output;
// the phase machine updates once per word. Asynchronous active-low reset clears
// the phase machine and both valid flags and loads the configuration defaults.
`default_nettype none

module json_string_field_extractor_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  text_byte,
    input  wire logic        end_of_text,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       value_byte,
    output logic             kind,
    output logic             found,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    typedef enum logic [3:0] {
        PH_SEARCH,
        PH_KEY,
        PH_KEY_CLOSED,
        PH_PRE_COLON,
        PH_POST_COLON,
        PH_VALUE,
        PH_ESCAPE,
        PH_HEX,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t     ph;
        logic [4:0] idx;
    } key_res_t;

    // configuration
    logic [63:0] key_chars_low_reg;
    logic [63:0] key_chars_high_reg;
    logic [4:0]  key_length_reg;
    logic [7:0]  max_value_len_reg;

    // scan state
    phase_t      phase_reg, phase_next;
    logic [4:0]  key_index_reg, key_index_next;
    logic [2:0]  hex_skip_reg, hex_skip_next;
    logic [7:0]  value_count_reg, value_count_next;

    // input register
    logic        in_valid_reg;
    logic [7:0]  text_byte_reg;
    logic        end_of_text_reg;

    // result register
    logic        out_valid_reg;
    logic [7:0]  value_byte_reg;
    logic        kind_reg;
    logic        found_reg;

    logic        advance;
    logic        res_valid;
    logic [7:0]  res_byte;
    logic        res_kind;
    logic        res_found;
    logic [4:0]  key_len;
    logic [7:0]  key_char;
    logic        text_ends;

    function automatic key_res_t key_fail(input logic [7:0] b, input logic [4:0] idx);
        key_res_t r;
        r.ph  = (b == jsfx_pkg::CH_QUOTE) ? PH_KEY : PH_SEARCH;
        r.idx = (b == jsfx_pkg::CH_QUOTE) ? 5'd0 : idx;
        return r;
    endfunction

    function automatic key_res_t key_step(input logic [7:0] b, input logic [4:0] idx,
                                          input logic [4:0] len, input logic [7:0] kc);
        key_res_t r;
        if (idx < len)
        begin
            if (b == kc)
            begin
                r.ph  = PH_KEY;
                r.idx = idx + 5'd1;
            end
            else
            begin
                r = key_fail(b, idx);
            end
        end
        else if (b == jsfx_pkg::CH_QUOTE)
        begin
            r.ph  = PH_KEY_CLOSED;
            r.idx = idx;
        end
        else
        begin
            r = key_fail(b, idx);
        end
        return r;
    endfunction

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign key_len  = (key_length_reg > 5'(jsfx_pkg::MAX_KEY_CHARS))
                      ? 5'(jsfx_pkg::MAX_KEY_CHARS) : key_length_reg;
    assign key_char = key_index_reg[3]
                      ? key_chars_high_reg[{key_index_reg[2:0], 3'b000} +: 8]
                      : key_chars_low_reg[{key_index_reg[2:0], 3'b000} +: 8];
    assign text_ends = (text_byte_reg == jsfx_pkg::CH_NUL) || end_of_text_reg;

    always_comb
    begin
        key_res_t   kr;
        logic       status;
        logic       emit;
        logic [7:0] emit_byte;

        phase_next       = phase_reg;
        key_index_next   = key_index_reg;
        hex_skip_next    = hex_skip_reg;
        value_count_next = value_count_reg;
        status           = 1'b0;
        res_found        = 1'b0;
        emit             = 1'b0;
        emit_byte        = text_byte_reg;
        kr               = '{ph: phase_reg, idx: key_index_reg};

        if (phase_reg == PH_DONE)
        begin
            // drop words up to the end of this text
        end
        else if (text_byte_reg == jsfx_pkg::CH_NUL)
        begin
            status = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_SEARCH:
                begin
                    if (text_byte_reg == jsfx_pkg::CH_QUOTE)
                    begin
                        phase_next     = PH_KEY;
                        key_index_next = 5'd0;
                    end
                end
                PH_KEY:
                begin
                    kr = key_step(text_byte_reg, key_index_reg, key_len, key_char);
                    phase_next     = kr.ph;
                    key_index_next = kr.idx;
                end
                PH_KEY_CLOSED:
                begin
                    if (jsfx_pkg::is_blank(text_byte_reg))
                    begin
                        phase_next = PH_PRE_COLON;
                    end
                    else if (text_byte_reg == jsfx_pkg::CH_COLON)
                    begin
                        phase_next = PH_POST_COLON;
                    end
                    else
                    begin
                        // closing quote opens a new attempt
                        kr = key_step(text_byte_reg, 5'd0, key_len, key_chars_low_reg[7:0]);
                        phase_next     = kr.ph;
                        key_index_next = kr.idx;
                    end
                end
                PH_PRE_COLON:
                begin
                    if (text_byte_reg == jsfx_pkg::CH_COLON)
                    begin
                        phase_next = PH_POST_COLON;
                    end
                    else if (!jsfx_pkg::is_blank(text_byte_reg))
                    begin
                        kr = key_fail(text_byte_reg, key_index_reg);
                        phase_next     = kr.ph;
                        key_index_next = kr.idx;
                    end
                end
                PH_POST_COLON:
                begin
                    if (text_byte_reg == jsfx_pkg::CH_QUOTE)
                    begin
                        phase_next = PH_VALUE;
                    end
                    else if (!jsfx_pkg::is_blank(text_byte_reg))
                    begin
                        phase_next = PH_SEARCH;
                    end
                end
                PH_VALUE:
                begin
                    if (text_byte_reg == jsfx_pkg::CH_QUOTE)
                    begin
                        status    = 1'b1;
                        res_found = 1'b1;
                    end
                    else if (text_byte_reg == jsfx_pkg::CH_BSLASH)
                    begin
                        phase_next = PH_ESCAPE;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                PH_ESCAPE:
                begin
                    phase_next = PH_VALUE;
                    emit       = 1'b1;
                    case (text_byte_reg)
                        jsfx_pkg::CH_LOW_N: emit_byte = jsfx_pkg::CH_LF;
                        jsfx_pkg::CH_LOW_R: emit_byte = jsfx_pkg::CH_CR;
                        jsfx_pkg::CH_LOW_T: emit_byte = jsfx_pkg::CH_TAB;
                        jsfx_pkg::CH_LOW_B: emit_byte = jsfx_pkg::CH_BS;
                        jsfx_pkg::CH_LOW_F: emit_byte = jsfx_pkg::CH_FF;
                        jsfx_pkg::CH_LOW_U:
                        begin
                            emit_byte     = jsfx_pkg::CH_QMARK;
                            phase_next    = PH_HEX;
                            hex_skip_next = 3'(jsfx_pkg::HEX_DIGITS);
                        end
                        default: emit_byte = text_byte_reg;
                    endcase
                end
                PH_HEX:
                begin
                    if (hex_skip_reg > 3'd1)
                    begin
                        hex_skip_next = hex_skip_reg - 3'd1;
                    end
                    else
                    begin
                        hex_skip_next = 3'd0;
                        phase_next    = PH_VALUE;
                    end
                end
                default:
                begin
                    phase_next = PH_SEARCH;
                end
            endcase
        end

        // drop value words past the length limit
        if (emit && !(value_count_reg < max_value_len_reg))
        begin
            emit = 1'b0;
        end
        if (emit)
        begin
            value_count_next = value_count_reg + 8'd1;
        end

        if (phase_reg != PH_DONE && !status && end_of_text_reg)
        begin
            status = 1'b1;
        end

        res_valid = emit || status;
        res_kind  = status;
        res_byte  = status ? 8'd0 : emit_byte;
        if (!status)
        begin
            res_found = 1'b0;
        end

        if (status && !text_ends)
        begin
            phase_next = PH_DONE;
        end
        else if (text_ends && (status || phase_reg == PH_DONE))
        begin
            phase_next       = PH_SEARCH;
            key_index_next   = 5'd0;
            hex_skip_next    = 3'd0;
            value_count_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_chars_low_reg  <= jsfx_pkg::KEY_LOW_RESET;
            key_chars_high_reg <= jsfx_pkg::KEY_HIGH_RESET;
            key_length_reg     <= jsfx_pkg::KEY_LEN_RESET;
            max_value_len_reg  <= jsfx_pkg::MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                jsfx_pkg::REG_KEY_LOW:  key_chars_low_reg  <= cfg_data;
                jsfx_pkg::REG_KEY_HIGH: key_chars_high_reg <= cfg_data;
                jsfx_pkg::REG_KEY_LEN:  key_length_reg     <= cfg_data[4:0];
                jsfx_pkg::REG_MAX_LEN:  max_value_len_reg  <= cfg_data[7:0];
                default:                key_length_reg     <= key_length_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SEARCH;
            key_index_reg   <= 5'd0;
            hex_skip_reg    <= 3'd0;
            value_count_reg <= 8'd0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            value_byte_reg  <= 8'd0;
            kind_reg        <= 1'b0;
            found_reg       <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                phase_reg       <= phase_next;
                key_index_reg   <= key_index_next;
                hex_skip_reg    <= hex_skip_next;
                value_count_reg <= value_count_next;
                out_valid_reg   <= res_valid;
                if (res_valid)
                begin
                    value_byte_reg <= res_byte;
                    kind_reg       <= res_kind;
                    found_reg      <= res_found;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            text_byte_reg   <= text_byte;
            end_of_text_reg <= end_of_text;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value_byte = value_byte_reg;
    assign kind       = kind_reg;
    assign found      = found_reg;

`include "json_string_field_extractor_unit_assert.svh"

    `JSFX_ASSERT_NOW(a_status_byte_zero, out_valid_reg && kind_reg, value_byte_reg == 8'd0)
    `JSFX_ASSERT_NOW(a_value_not_found, out_valid_reg && !kind_reg, !found_reg)
    `JSFX_ASSERT_NOW(a_ready_when_empty, !out_valid_reg, in_ready)
    `JSFX_ASSERT_NEXT(a_status_to_done, advance && res_valid && res_kind && !text_ends,
                      phase_reg == PH_DONE)
    `JSFX_ASSERT_NEXT(a_count_steps, advance && res_valid && !res_kind,
                      value_count_reg == $past(value_count_reg) + 8'd1)

endmodule

`default_nettype wire
